// ===== sv/tsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tab-separated record parser: shared definitions
// Character codes, sizes, register map and the line result type.
// ----------------------------------------------------------------------------
package tsrp_pkg;

  localparam int MAX_CHARS  = 16;
  localparam int NUM_COLS   = 4;
  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int PRIO_W     = 8;
  localparam int COL_IDX_W  = 3;
  localparam int COL_W      = $clog2(NUM_COLS);
  localparam int CNT_W      = $clog2(MAX_CHARS + 1);

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] DIGIT_MAX = 8'd9;

  // Input word kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PRIO_LIMIT = 1'b0;
  localparam logic [PRIO_W-1:0] PRIO_LIMIT_RESET = 8'd255;

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] process_id;
    logic [VALUE_W-1:0] burst_time;
    logic [VALUE_W-1:0] arrival_time;
    logic [PRIO_W-1:0]  priority_level;
  } line_out_t;

endpackage

// ===== sv/tsrp_if.sv =====
// ----------------------------------------------------------------------------
// Tab-separated record parser: channel interfaces
// Valid/ready channels for the text bytes and for the parsed records.
// ----------------------------------------------------------------------------
interface tsrp_text_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [tsrp_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, kind, text_byte, input ready);
  modport sink (input valid, kind, text_byte, output ready);
endinterface

interface tsrp_rec_if;
  logic                         valid;
  logic                         ready;
  logic [tsrp_pkg::VALUE_W-1:0] process_id;
  logic [tsrp_pkg::VALUE_W-1:0] burst_time;
  logic [tsrp_pkg::VALUE_W-1:0] arrival_time;
  logic [tsrp_pkg::PRIO_W-1:0]  priority_level;

  modport source (output valid, process_id, burst_time, arrival_time, priority_level,
                  input ready);
  modport sink (input valid, process_id, burst_time, arrival_time, priority_level,
                output ready);
endinterface

// ===== sv/tsrp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Tab-separated record parser: configuration registers
// APB-style register file holding the priority limit.
// ----------------------------------------------------------------------------
module tsrp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsrp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tsrp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tsrp_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [tsrp_pkg::PRIO_W-1:0]   prio_limit
);
  import tsrp_pkg::*;

  logic reg_index;

  // Registers sit on word boundaries; the low address bits are ignored.
  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_limit <= PRIO_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_PRIO_LIMIT) begin
      prio_limit <= pwdata[PRIO_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PRIO_LIMIT: prdata = {{(APB_DATA_W-PRIO_W){1'b0}}, prio_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/tsrp_line_acc.sv =====
// ----------------------------------------------------------------------------
// Tab-separated record parser: line accumulator
// Holds the column state of the current line and decides at end of line
// whether it forms a valid record.
// ----------------------------------------------------------------------------
module tsrp_line_acc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        kind,
  input  logic [tsrp_pkg::BYTE_W-1:0] text_byte,
  input  logic [tsrp_pkg::PRIO_W-1:0] prio_limit,
  output tsrp_pkg::line_out_t         line
);
  import tsrp_pkg::*;

  logic [COL_IDX_W-1:0] column_index;
  logic [CNT_W-1:0]     char_count;
  logic [VALUE_W-1:0]   column_value [NUM_COLS];
  logic [NUM_COLS-1:0]  column_bad;
  logic [NUM_COLS-1:0]  column_nonempty;
  logic                 skip_to_eol;

  logic               is_eol;
  logic               is_tab;
  logic [BYTE_W-1:0]  digit;
  logic               is_digit;
  logic [COL_W-1:0]   col;
  logic [VALUE_W-1:0] acc_next;
  logic               line_ok;

  assign is_eol   = (kind == KIND_EOS) || text_byte == CHAR_CR || text_byte == CHAR_LF;
  assign is_tab   = text_byte == CHAR_TAB;
  // Bytes below '0' wrap round to large values, so one compare covers both ends.
  assign digit    = text_byte - CHAR_ZERO;
  assign is_digit = digit <= DIGIT_MAX;
  assign col      = column_index[COL_W-1:0];
  assign acc_next = (column_value[col] << 3) + (column_value[col] << 1)
                    + {{(VALUE_W-BYTE_W){1'b0}}, digit};

  assign line_ok = (column_index >= COL_IDX_W'(NUM_COLS - 1))
                   && (&column_nonempty) && !(|column_bad)
                   && column_value[1] != '0
                   && column_value[3] <= {{(VALUE_W-PRIO_W){1'b0}}, prio_limit};

  always_comb begin
    line.emit           = is_eol && line_ok;
    line.process_id     = column_value[0];
    line.burst_time     = column_value[1];
    line.arrival_time   = column_value[2];
    line.priority_level = column_value[3][PRIO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_eol)) begin
      column_index    <= '0;
      char_count      <= '0;
      column_bad      <= '0;
      column_nonempty <= '0;
      skip_to_eol     <= 1'b0;
      for (int i = 0; i < NUM_COLS; i++) begin
        column_value[i] <= '0;
      end
    end else if (step && !skip_to_eol) begin
      if (is_tab) begin
        column_index <= column_index + 1'b1;
        char_count   <= '0;
        if (column_index == COL_IDX_W'(NUM_COLS - 1)) begin
          skip_to_eol <= 1'b1;
        end
      end else if (char_count < CNT_W'(MAX_CHARS)) begin
        char_count           <= char_count + 1'b1;
        column_nonempty[col] <= 1'b1;
        if (is_digit) begin
          column_value[col] <= acc_next;
        end else begin
          column_bad[col] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/tab_separated_record_parser.sv =====
// ----------------------------------------------------------------------------
// Tab-separated record parser: top level
// Splits a byte stream into lines of four tab-separated decimal columns and
// emits one record for each well-formed line with a non-zero burst and a priority within the limit.
// ----------------------------------------------------------------------------
// Usage:
//   text_ch carries one word per cycle: kind 0 is a data byte, kind 1 marks
//   end of stream and closes the pending line. rec_ch carries one record
//   (process id, burst, arrival, priority) per accepted line; malformed
//   lines, zero bursts and priorities above the priority limit give nothing.
//   The priority limit is written over the APB port, at byte address 0.
//   Throughput is one word per cycle. Each word passes through the input
//   register; the record it closes is registered in the output register
//   as that word leaves the input register and is then presented on rec_ch.
//   The output register frees the input side: bytes keep flowing while a
//   record waits. Only a line end that would emit a record while the output
//   register is still full waits in the input register, and text_ch.ready
//   drops until rec_ch is drained.
//   Reset clears the line state, empties both registers and sets the
//   priority limit to 255.
// ----------------------------------------------------------------------------
module tab_separated_record_parser (
  input  logic                            clk,
  input  logic                            rst,
  tsrp_text_if.sink                       text_ch,
  tsrp_rec_if.source                      rec_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsrp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tsrp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tsrp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tsrp_pkg::*;

  logic              s1_valid;
  logic              s1_kind;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_advance;
  logic              step;
  logic [PRIO_W-1:0] prio_limit;
  line_out_t         line;

  tsrp_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .prio_limit (prio_limit)
  );

  tsrp_line_acc u_line (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .kind       (s1_kind),
    .text_byte  (s1_byte),
    .prio_limit (prio_limit),
    .line       (line)
  );

  // A word only has to wait when it produces a record and the output is full and stalled.
  assign s1_advance    = !line.emit || !rec_ch.valid || rec_ch.ready;
  assign step          = s1_valid && s1_advance;
  assign text_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_ch.ready) begin
      s1_valid <= text_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ch.ready && text_ch.valid) begin
      s1_kind <= text_ch.kind;
      s1_byte <= text_ch.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_ch.valid <= 1'b0;
    end else if (step && line.emit) begin
      rec_ch.valid <= 1'b1;
    end else if (rec_ch.ready) begin
      rec_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && line.emit) begin
      rec_ch.process_id     <= line.process_id;
      rec_ch.burst_time     <= line.burst_time;
      rec_ch.arrival_time   <= line.arrival_time;
      rec_ch.priority_level <= line.priority_level;
    end
  end

  // A record never carries a zero burst.
  assert property (@(posedge clk) disable iff (rst)
    rec_ch.valid |-> rec_ch.burst_time != '0)
    else $error("record with zero burst");

  // The input side only stalls behind a full, stalled output register.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> (rec_ch.valid && !rec_ch.ready))
    else $error("input stalled without output back-pressure");

  // Ready can only be low while a word is held.
  assert property (@(posedge clk) disable iff (rst)
    !text_ch.ready |-> s1_valid)
    else $error("ready low with empty input register");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !rec_ch.valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/tsrp_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tab-separated record parser: record checker
// Watches the text and record channels and the APB port. It keeps its own
// copy of the line state, works out the record that each line end should
// give, and compares every record taken from the block with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module tsrp_record_checker (
  input  logic                            clk,
  input  logic                            rst,
  tsrp_text_if                            text_ch,
  tsrp_rec_if                             rec_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsrp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tsrp_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [tsrp_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int unsigned                     error_count,
  output int unsigned                     records_pending
);
  import tsrp_pkg::*;

  localparam logic [APB_ADDR_W-1:0] PRIO_LIMIT_ADDR = APB_ADDR_W'(4 * REG_PRIO_LIMIT);

  typedef struct packed {
    logic [VALUE_W-1:0] process_id;
    logic [VALUE_W-1:0] burst_time;
    logic [VALUE_W-1:0] arrival_time;
    logic [PRIO_W-1:0]  priority_level;
  } record_t;

  record_t owed_records[$];

  logic [COL_IDX_W-1:0] col_idx;
  logic [CNT_W-1:0]     char_cnt;
  logic [VALUE_W-1:0]   col_val [NUM_COLS];
  logic [NUM_COLS-1:0]  col_bad;
  logic [NUM_COLS-1:0]  col_seen;
  logic                 skipping;
  logic [PRIO_W-1:0]    max_prio;
  int unsigned          mismatches = 0;

  task automatic clear_line();
    col_idx  = '0;
    char_cnt = '0;
    for (int i = 0; i < NUM_COLS; i++) col_val[i] = '0;
    col_bad  = '0;
    col_seen = '0;
    skipping = 1'b0;
  endtask

  // Advances the line state by one word and queues the record that a
  // well-formed line end gives.
  task automatic parse_text_word(input logic kind, input logic [BYTE_W-1:0] ch);
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] digit;
    logic              ok;
    record_t           rec;
    if (kind == KIND_EOS || ch == CHAR_CR || ch == CHAR_LF) begin
      ok = (col_idx >= 3) && (&col_seen) && !(|col_bad) && (col_val[1] != '0) &&
           (col_val[3] <= {{(VALUE_W-PRIO_W){1'b0}}, max_prio});
      if (ok) begin
        rec.process_id     = col_val[0];
        rec.burst_time     = col_val[1];
        rec.arrival_time   = col_val[2];
        rec.priority_level = col_val[3][PRIO_W-1:0];
        owed_records.push_back(rec);
      end
      clear_line();
    end else if (!skipping) begin
      if (ch == CHAR_TAB) begin
        col_idx++;
        char_cnt = '0;
        if (col_idx >= NUM_COLS) skipping = 1'b1;
      end else begin
        col = col_idx[COL_W-1:0];
        // Bytes past the counted width of a column are dropped, digits or not.
        if (char_cnt < MAX_CHARS) begin
          char_cnt++;
          col_seen[col] = 1'b1;
          digit = ch - CHAR_ZERO;
          if (digit > DIGIT_MAX) col_bad[col] = 1'b1;
          else col_val[col] = col_val[col] * 10 + digit;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      clear_line();
      max_prio = PRIO_LIMIT_RESET;
      owed_records.delete();
    end else begin
      if (rec_ch.valid && rec_ch.ready) begin
        if (owed_records.size() == 0) begin
          $error("record %0d/%0d/%0d/%0d arrived with none owed", rec_ch.process_id,
                 rec_ch.burst_time, rec_ch.arrival_time, rec_ch.priority_level);
          mismatches++;
        end else begin
          want = owed_records.pop_front();
          if (rec_ch.process_id !== want.process_id) begin
            $error("process_id: expected %0d, got %0d", want.process_id, rec_ch.process_id);
            mismatches++;
          end
          if (rec_ch.burst_time !== want.burst_time) begin
            $error("burst_time: expected %0d, got %0d", want.burst_time, rec_ch.burst_time);
            mismatches++;
          end
          if (rec_ch.arrival_time !== want.arrival_time) begin
            $error("arrival_time: expected %0d, got %0d", want.arrival_time,
                   rec_ch.arrival_time);
            mismatches++;
          end
          if (rec_ch.priority_level !== want.priority_level) begin
            $error("priority_level: expected %0d, got %0d", want.priority_level,
                   rec_ch.priority_level);
            mismatches++;
          end
        end
      end
      if (text_ch.valid && text_ch.ready) parse_text_word(text_ch.kind, text_ch.text_byte);
      if (psel && penable && pready && paddr == PRIO_LIMIT_ADDR) begin
        if (pwrite) begin
          max_prio = pwdata[PRIO_W-1:0];
        end else if (prdata[PRIO_W-1:0] !== max_prio) begin
          $error("prdata: expected %0d, got %0d", max_prio, prdata[PRIO_W-1:0]);
          mismatches++;
        end
      end
    end
    error_count     <= mismatches;
    records_pending <= owed_records.size();
  end

endmodule

// ===== verif/tab_separated_record_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tab-separated record parser: testbench top
// Feeds the parser with short directed lines and then with random lines,
// mostly well formed, across phases of differing idle rates and priority
// limits. The record checker beside the block does the predicting and the
// comparing; this module drives the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tab_separated_record_parser_tb;
  import tsrp_pkg::*;

  localparam logic [APB_ADDR_W-1:0] PRIO_LIMIT_ADDR = APB_ADDR_W'(4 * REG_PRIO_LIMIT);
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS    = 330;
  localparam int unsigned DIRECTED_WORDS = 25;

  typedef enum int unsigned {END_LF, END_CR, END_CRLF, END_EOS} line_end_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           error_count;
  int unsigned           records_pending;

  int unsigned           src_idle_pct  = 0;
  int unsigned           rec_stall_pct = 0;
  int unsigned           rec_hold_req  = 0;
  int unsigned           words_sent    = 0;
  logic [PRIO_W-1:0]     cur_max_prio  = PRIO_LIMIT_RESET;

  tsrp_text_if text_ch();
  tsrp_rec_if  rec_ch();

  tab_separated_record_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .text_ch (text_ch),
    .rec_ch  (rec_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsrp_record_checker u_record_checker (
    .clk             (clk),
    .rst             (rst),
    .text_ch         (text_ch),
    .rec_ch          (rec_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .error_count     (error_count),
    .records_pending (records_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record receiver. A hold request stalls it for a long stretch so that the
  // output register fills and the parser has to refuse text words.
  initial begin
    int unsigned n;
    forever begin
      if (rec_hold_req != 0) begin
        n = rec_hold_req;
        rec_hold_req = 0;
        repeat (n) begin
          rec_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        rec_ch.ready <= ($urandom_range(99) >= rec_stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((text_ch.valid && text_ch.ready) || (rec_ch.valid && rec_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [BYTE_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.kind      <= kind;
    text_ch.text_byte <= value;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(KIND_DATA, s[i]);
  endtask

  task automatic send_line_end(input line_end_t ending);
    case (ending)
      END_LF: send_word(KIND_DATA, CHAR_LF);
      END_CR: send_word(KIND_DATA, CHAR_CR);
      END_CRLF: begin
        send_word(KIND_DATA, CHAR_CR);
        send_word(KIND_DATA, CHAR_LF);
      end
      default: send_word(KIND_EOS, BYTE_W'($urandom_range(255)));
    endcase
  endtask

  // Mostly short columns, some long enough to wrap, a few past the counted
  // width with printable junk in the ignored tail.
  function automatic int unsigned digit_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  task automatic push_digits(ref logic [BYTE_W-1:0] q[$], input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (i >= MAX_CHARS && $urandom_range(3) == 0)
        q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7e)));
      else
        q.push_back(CHAR_ZERO + BYTE_W'($urandom_range(9)));
    end
  endtask

  task automatic push_decimal(ref logic [BYTE_W-1:0] q[$], input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic send_random_line();
    logic [BYTE_W-1:0] q[$];
    int unsigned       shape;
    int unsigned       r;
    int unsigned       ncols;
    line_end_t         ending;
    shape = $urandom_range(99);
    if (shape < 75) begin
      push_digits(q, digit_count());
      q.push_back(CHAR_TAB);
      if ($urandom_range(19) == 0) q.push_back(CHAR_ZERO);
      else push_digits(q, digit_count());
      q.push_back(CHAR_TAB);
      push_digits(q, digit_count());
      q.push_back(CHAR_TAB);
      r = $urandom_range(99);
      if (r < 60) push_decimal(q, $urandom_range(cur_max_prio));
      else if (r < 90) push_decimal(q, $urandom_range(255));
      else push_digits(q, digit_count());
      // Anything after a fourth tab is skipped up to the line end.
      if ($urandom_range(5) == 0) begin
        q.push_back(CHAR_TAB);
        repeat ($urandom_range(6)) q.push_back(BYTE_W'($urandom_range(8'h0e, 8'hff)));
      end
      if ($urandom_range(9) == 0) q[$urandom_range(q.size() - 1)] = BYTE_W'($urandom_range(255));
    end else if (shape < 88) begin
      ncols = $urandom_range(1, 4);
      for (int unsigned c = 0; c < ncols; c++) begin
        if (c > 0) q.push_back(CHAR_TAB);
        if ($urandom_range(3) != 0) push_digits(q, digit_count());
      end
    end else begin
      repeat ($urandom_range(1, 12)) q.push_back(BYTE_W'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 50) ending = END_LF;
    else if (r < 70) ending = END_CR;
    else if (r < 90) ending = END_CRLF;
    else ending = END_EOS;
    foreach (q[i]) send_word(KIND_DATA, q[i]);
    send_line_end(ending);
  endtask

  // Lets every owed record come out, then waits on so that a line end
  // still in the input register is evaluated before any register write.
  task automatic drain_records();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the limit, then reads it back in the next transfer.
  task automatic write_prio_limit(input logic [PRIO_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PRIO_LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_max_prio = value;
  endtask

  initial begin
    logic [PRIO_W-1:0] limit;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.kind      <= KIND_DATA;
    text_ch.text_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Blank lines, a plain record, end of stream while skipping a tail, and a
    // line that starts straight after end of stream.
    send_word(KIND_DATA, CHAR_CR);
    send_word(KIND_DATA, CHAR_LF);
    send_text("9\t1\t0\t7");
    send_word(KIND_DATA, CHAR_LF);
    send_text("1\t2\t3\t4\t");
    send_word(KIND_DATA, 8'hff);
    send_word(KIND_EOS, 8'hff);
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_EOS, 8'h00);

    for (int p = 0; p < 4; p++) begin
      drain_records();
      case (p)
        0: limit = 8'd255;
        1: limit = 8'd0;
        2: limit = PRIO_W'($urandom_range(1, 254));
        default: limit = PRIO_W'($urandom_range(255));
      endcase
      write_prio_limit(limit);
      case (p)
        0: begin
          src_idle_pct  = 0;
          rec_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 54;
          rec_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          rec_stall_pct = 54;
        end
        default: begin
          src_idle_pct  = 11;
          rec_stall_pct = 11;
        end
      endcase
      if (p == 0) begin
        rec_hold_req = 300;
        repeat (20) begin
          send_text($sformatf("%0d\t%0d\t%0d\t0", $urandom, $urandom_range(1, 999), $urandom));
          send_line_end(END_LF);
        end
      end
      while (words_sent < DIRECTED_WORDS + (p + 1) * PHASE_WORDS) send_random_line();
    end

    drain_records();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
